[hdl/ang_pkg.sv]
// Shared widths, register indexes, microcode format and program ROM for the noise gate.
`default_nettype none

package ang_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int GAIN_W     = COEF_W + 1;
    localparam int THR_W      = SAMPLE_W - 1;
    localparam int OPA_W      = 25;
    localparam int OPB_W      = 25;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 4;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << COEF_W;

    localparam logic [COEF_W-1:0] DECAY_RST   = 24'd16742300;
    localparam logic [COEF_W-1:0] ATTACK_RST  = 24'd16707456;
    localparam logic [COEF_W-1:0] RELEASE_RST = 24'd16775468;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd3;

    // Operand load selects
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ENV  = 2'd1;
    localparam logic [1:0] OP_GAIN = 2'd2;
    localparam logic [1:0] OP_OUT  = 2'd3;

    // Jump conditions
    localparam logic [2:0] JC_NONE     = 3'd0;
    localparam logic [2:0] JC_ALWAYS   = 3'd1;
    localparam logic [2:0] JC_NO_IN    = 3'd2;
    localparam logic [2:0] JC_ENV_UP   = 3'd3;
    localparam logic [2:0] JC_OUT_BUSY = 3'd4;

    // Program steps
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_ENV      = 4'd1;
    localparam logic [STEP_W-1:0] ST_ENV_MUL  = 4'd2;
    localparam logic [STEP_W-1:0] ST_ENV_UPD  = 4'd3;
    localparam logic [STEP_W-1:0] ST_GAIN_LD  = 4'd4;
    localparam logic [STEP_W-1:0] ST_GAIN_MUL = 4'd5;
    localparam logic [STEP_W-1:0] ST_GAIN_UPD = 4'd6;
    localparam logic [STEP_W-1:0] ST_OUT_LD   = 4'd7;
    localparam logic [STEP_W-1:0] ST_OUT_MUL  = 4'd8;
    localparam logic [STEP_W-1:0] ST_OUT      = 4'd9;
    localparam logic [STEP_W-1:0] ST_WRAP     = 4'd10;

    typedef struct packed {
        logic              take;
        logic [1:0]        opsel;
        logic              mul;
        logic              env_upd;
        logic              gain_upd;
        logic              out_wr;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } uop_t;

    function automatic uop_t ucode_rom(input logic [STEP_W-1:0] step);
        uop_t w;
        begin
            w = '0;
            w.cond = JC_ALWAYS;
            w.target = ST_IDLE;
            case (step)
                ST_IDLE:
                begin
                    w.take = 1'b1;
                    w.cond = JC_NO_IN;
                    w.target = ST_IDLE;
                end
                ST_ENV:
                begin
                    w.opsel = OP_ENV;
                    w.cond = JC_ENV_UP;
                    w.target = ST_GAIN_LD;
                end
                ST_ENV_MUL:
                begin
                    w.mul = 1'b1;
                    w.cond = JC_NONE;
                end
                ST_ENV_UPD:
                begin
                    w.env_upd = 1'b1;
                    w.cond = JC_NONE;
                end
                ST_GAIN_LD:
                begin
                    w.opsel = OP_GAIN;
                    w.cond = JC_NONE;
                end
                ST_GAIN_MUL:
                begin
                    w.mul = 1'b1;
                    w.cond = JC_NONE;
                end
                ST_GAIN_UPD:
                begin
                    w.gain_upd = 1'b1;
                    w.cond = JC_NONE;
                end
                ST_OUT_LD:
                begin
                    w.opsel = OP_OUT;
                    w.cond = JC_NONE;
                end
                ST_OUT_MUL:
                begin
                    w.mul = 1'b1;
                    w.cond = JC_NONE;
                end
                ST_OUT:
                begin
                    w.out_wr = 1'b1;
                    w.cond = JC_OUT_BUSY;
                    w.target = ST_OUT;
                end
                ST_WRAP:
                begin
                    w.cond = JC_ALWAYS;
                    w.target = ST_IDLE;
                end
                default:
                begin
                    w.cond = JC_ALWAYS;
                    w.target = ST_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/ang_if.sv]
// Valid/ready channel interfaces for the input samples and the gated results.
`default_nettype none

interface ang_sample_if;
    import ang_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface ang_result_if;
    import ang_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       gate_open;

    modport source (output valid, output sample_out, output gate_open, input ready);
    modport sink (input valid, input sample_out, input gate_open, output ready);
endinterface

`default_nettype wire

[hdl/audio_noise_gate.sv]
// Noise gate with envelope follower: top level, microcoded sequencer and datapath.
//
// Usage:
//   din  carries one signed Q1.23 sample per item (valid/ready).
//   dout carries one result per input item: the gated sample (Q1.23) and
//        the gate_open flag computed from this sample's envelope.
//   cfg_we/cfg_index/cfg_data write the threshold (index 0), envelope decay
//        (1), attack (2) and release (3) coefficients; write only while idle.
// Timing:
//   A short microprogram walks one shared 25x25 multiplier through the
//   products of each item: envelope decay (skipped when the envelope jumps
//   up to the new magnitude), gain smoothing and output scaling. Its steps
//   load, multiply and update in turn and end in the result register; the
//   next item is taken only after the program has wrapped back to idle.
// Reset:
//   Envelope clears to zero, gain opens to one, coefficients take their
//   default values, and the output register empties.
// Stall:
//   The result sits in an output register; the next item is accepted and
//   processed while it waits, and the program holds at its output step only
//   when the new result would overwrite one that is still not taken.
`default_nettype none

module audio_noise_gate (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ang_sample_if.sink                          din,
    ang_result_if.source                        dout,
    input  wire logic                           cfg_we,
    input  wire logic [ang_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ang_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ang_pkg::*;

    // Sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    uop_t              uop;
    logic              jump;

    // Configuration
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [COEF_W-1:0] decay_reg, decay_next;
    logic [COEF_W-1:0] attack_reg, attack_next;
    logic [COEF_W-1:0] release_reg, release_next;

    // Filter state
    logic [SAMPLE_W-1:0] env_reg, env_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;

    // Per-item working registers
    logic [SAMPLE_W-1:0] mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic                open_reg, open_next;
    logic                rise_reg, rise_next;
    logic [OPA_W-1:0]    op_a_reg, op_a_next;
    logic [OPB_W-1:0]    op_b_reg, op_b_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                out_open_reg, out_open_next;

    logic                accept_in;
    logic                env_up;
    logic                out_busy;
    logic                open_now;
    logic                rise_now;
    logic [SAMPLE_W-1:0] raw_in;
    logic [SAMPLE_W-1:0] prod_hi_s;
    logic [GAIN_W-1:0]   prod_hi_g;
    logic                prod_frac;
    logic [SAMPLE_W-1:0] q_up;

    assign uop       = ucode_rom(step_reg);
    assign din.ready = uop.take;
    assign accept_in = din.valid && din.ready;
    assign env_up    = mag_reg > env_reg;
    assign out_busy  = out_valid_reg && !dout.ready;
    assign raw_in    = din.sample_in;

    assign open_now  = env_reg > {1'b0, thr_reg};
    assign rise_now  = open_now && (gain_reg != GAIN_ONE);

    assign prod_hi_s = prod_reg[COEF_W +: SAMPLE_W];
    assign prod_hi_g = prod_reg[COEF_W +: GAIN_W];
    assign prod_frac = |prod_reg[COEF_W-1:0];
    assign q_up      = prod_hi_s + {{(SAMPLE_W-1){1'b0}}, prod_frac};

    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_sample_reg;
    assign dout.gate_open  = out_open_reg;

    // Step counter: advance, or take the microcoded jump
    always_comb
    begin
        case (uop.cond)
            JC_NONE:     jump = 1'b0;
            JC_ALWAYS:   jump = 1'b1;
            JC_NO_IN:    jump = !din.valid;
            JC_ENV_UP:   jump = env_up;
            JC_OUT_BUSY: jump = out_busy;
            default:     jump = 1'b1;
        endcase
        step_next = jump ? uop.target : step_reg + 1'b1;
    end

    // Configuration writes
    always_comb
    begin
        thr_next     = thr_reg;
        decay_next   = decay_reg;
        attack_next  = attack_reg;
        release_next = release_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_next     = cfg_data[THR_W-1:0];
                REG_DECAY:     decay_next   = cfg_data[COEF_W-1:0];
                REG_ATTACK:    attack_next  = cfg_data[COEF_W-1:0];
                REG_RELEASE:   release_next = cfg_data[COEF_W-1:0];
                default:       thr_next     = thr_reg;
            endcase
        end
    end

    // Datapath driven by the current control word
    always_comb
    begin
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        env_next        = env_reg;
        gain_next       = gain_reg;
        open_next       = open_reg;
        rise_next       = rise_reg;
        op_a_next       = op_a_reg;
        op_b_next       = op_b_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !dout.ready;
        out_sample_next = out_sample_reg;
        out_open_next   = out_open_reg;

        // Take the sample; the most negative code maps to magnitude 2^23
        if (accept_in)
        begin
            neg_next = raw_in[SAMPLE_W-1];
            mag_next = raw_in[SAMPLE_W-1] ? (~raw_in + 1'b1) : raw_in;
        end

        case (uop.opsel)
            OP_ENV:
            begin
                if (env_up)
                begin
                    env_next = mag_reg;
                end
                else
                begin
                    op_a_next = {1'b0, env_reg - mag_reg};
                    op_b_next = {1'b0, decay_reg};
                end
            end
            OP_GAIN:
            begin
                open_next = open_now;
                rise_next = rise_now;
                if (rise_now)
                begin
                    op_a_next = GAIN_ONE - gain_reg;
                    op_b_next = {1'b0, attack_reg};
                end
                else
                begin
                    op_a_next = open_now ? (gain_reg - GAIN_ONE) : gain_reg;
                    op_b_next = {1'b0, release_reg};
                end
            end
            OP_OUT:
            begin
                op_a_next = {1'b0, mag_reg};
                op_b_next = gain_reg;
            end
            default:
            begin
                op_a_next = op_a_reg;
            end
        endcase

        if (uop.mul)
        begin
            prod_next = op_a_reg * op_b_reg;
        end

        if (uop.env_upd)
        begin
            env_next = mag_reg + prod_hi_s;
        end

        // Rising gain rounds its remaining distance to one up; falling gain truncates
        if (uop.gain_upd)
        begin
            if (rise_reg)
            begin
                gain_next = GAIN_ONE - (prod_hi_g + {{(GAIN_W-1){1'b0}}, prod_frac});
            end
            else
            begin
                gain_next = (open_reg ? GAIN_ONE : '0) + prod_hi_g;
            end
        end

        // Floor of the signed product: negate the ceiling for negative input
        if (uop.out_wr && !out_busy)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = neg_reg ? (~q_up + 1'b1) : prod_hi_s;
            out_open_next   = open_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            thr_reg       <= '0;
            decay_reg     <= DECAY_RST;
            attack_reg    <= ATTACK_RST;
            release_reg   <= RELEASE_RST;
            env_reg       <= '0;
            gain_reg      <= GAIN_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            thr_reg       <= thr_next;
            decay_reg     <= decay_next;
            attack_reg    <= attack_next;
            release_reg   <= release_next;
            env_reg       <= env_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        open_reg       <= open_next;
        rise_reg       <= rise_next;
        op_a_reg       <= op_a_next;
        op_b_reg       <= op_b_next;
        prod_reg       <= prod_next;
        out_sample_reg <= out_sample_next;
        out_open_reg   <= out_open_next;
    end

    // An accepted item always starts the envelope step next
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> (step_reg == ST_ENV))
        else $error("accepted item did not start the program");

    // Gain stays within [0, one]
    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GAIN_ONE)
        else $error("gate gain exceeds one");

    // Updated envelope is never below the current magnitude
    a_env_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_GAIN_LD) |-> (env_reg >= mag_reg))
        else $error("envelope below sample magnitude");

    // A result appears only from the output step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(step_reg) == ST_OUT))
        else $error("result written outside the output step");

endmodule

`default_nettype wire
